>>> design/srsw_pkg.sv
// srsw_pkg: types and constants shared by the selective repeat send window
// no dependencies
package srsw_pkg;

   localparam int CRC_BYTES  = 4;
   localparam int MAX_LEN    = 256;
   localparam int RESULT_CAP = 8;

   typedef enum logic [1:0] {
      KIND_RESERVE = 2'd0,
      KIND_STREAM  = 2'd1,
      KIND_ACK     = 2'd2,
      KIND_POLL    = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_MAX_PACKET = 1'b0,
      CSR_RETX_AGE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] payload_bytes;
      logic [7:0]  ack_seqnum;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] seqnum;
      logic [9:0] buffer_offset;
      logic [8:0] pkt_length;
      logic [8:0] payload_taken;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] max_pkt_size;
      logic [7:0] retransmit_age;
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STREAM,
      ST_ACK_WALK,
      ST_POLL_WALK,
      ST_EMIT,
      ST_CLOSE
   } state_type;

endpackage

>>> design/selective_repeat_send_window.sv
// selective_repeat_send_window: top level of the sender window bookkeeping
// depends on srsw_pkg, srsw_fifo, srsw_engine, srsw_out
//
//  channel | ports                           | handshake
//  request | req_push req_full req_data      | push && !full
//  result  | rsp_pop rsp_empty rsp_data      | pop && !empty
//  csr     | csr_valid csr_ready csr_index/d | valid && ready
//
// engine steps: reserve takes the request and hands over the result; stream hands over each packet, then closes;
// acknowledge at the window head and poll walk the window slot by slot before handing over
// a stream packet waits in the result queue until the next packet or the close
// synchronous reset clears window, ring pointers, age clock and valid bits
// a stalled result side holds the engine; the request queue holds two requests
module selective_repeat_send_window
   import srsw_pkg::*;
#(
   parameter int WINDOW_SLOTS        = 8,
   parameter int RING_BYTES          = 1024,
   parameter int HEADER_BYTES        = 4,
   parameter int STREAM_HEADER_BYTES = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   csr_type csr_ff;
   logic    q_empty, q_pop, e_valid, e_ready, e_close;
   req_type q_data;
   rsp_type e_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_pkt_size   <= 8'd0;
         csr_ff.retransmit_age <= 8'd4;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_PACKET: csr_ff.max_pkt_size   <= csr_data;
            CSR_RETX_AGE:   csr_ff.retransmit_age <= csr_data;
            default: ;
         endcase
      end
   end

   srsw_fifo #(.DEPTH(2)) u_fifo (
      .clock(clock), .reset(reset), .push(req_push), .push_data(req_data),
      .full(req_full), .pop(q_pop), .empty(q_empty), .pop_data(q_data));

   srsw_engine #(
      .WINDOW_SLOTS(WINDOW_SLOTS), .RING_BYTES(RING_BYTES),
      .HEADER_BYTES(HEADER_BYTES), .STREAM_HEADER_BYTES(STREAM_HEADER_BYTES)
   ) u_engine (
      .clock(clock), .reset(reset), .csr(csr_ff), .cmd_empty(q_empty),
      .cmd(q_data), .cmd_pop(q_pop), .out_valid(e_valid), .out_data(e_data),
      .out_ready(e_ready), .out_close(e_close));

   srsw_out u_out (
      .clock(clock), .reset(reset), .in_valid(e_valid), .in_data(e_data),
      .in_close(e_close), .in_ready(e_ready), .empty(rsp_empty),
      .data(rsp_data), .pop(rsp_pop));

`ifndef SYNTH
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("engine took a request from an empty queue");
   a_last_set: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.ok) |-> rsp_data.last)
      else $error("refusal without last");
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.ok) |-> (rsp_data.pkt_length == '0))
      else $error("refusal carries a length");
`endif
endmodule

>>> design/srsw_fifo.sv
// srsw_fifo: small request queue between front and back
// depends on srsw_pkg
module srsw_fifo
   import srsw_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output req_type pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type        mem_ff [DEPTH];
   logic [AW-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop && !empty) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) cnt_in = cnt_ff + 1'b1;
      else if (!(push && !full) && (pop && !empty)) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wp_ff] <= push_data;
   end
endmodule

>>> design/srsw_engine.sv
// srsw_engine: window and ring bookkeeping, one request at a time
// depends on srsw_pkg
module srsw_engine
   import srsw_pkg::*;
#(
   parameter int WINDOW_SLOTS        = 8,
   parameter int RING_BYTES          = 1024,
   parameter int HEADER_BYTES        = 4,
   parameter int STREAM_HEADER_BYTES = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  csr_type csr,
   input  logic    cmd_empty,
   input  req_type cmd,
   output logic    cmd_pop,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready,
   output logic    out_close
);
   localparam int SW = $clog2(WINDOW_SLOTS);
   localparam int RW = $clog2(RING_BYTES) + 1;
   localparam int OVH = STREAM_HEADER_BYTES + CRC_BYTES;

   state_type state_ff, state_in;
   logic [7:0]    whead_ff, whead_in, wtail_ff, wtail_in, age_ff, age_in;
   logic [RW-1:0] rhead_ff, rhead_in, rtail_ff, rtail_in;
   logic [WINDOW_SLOTS-1:0] valid_ff, valid_in;
   logic          acked_ff [WINDOW_SLOTS];
   logic [RW-1:0] off_ff   [WINDOW_SLOTS];
   logic [8:0]    len_ff   [WINDOW_SLOTS];
   logic [7:0]    stamp_ff [WINDOW_SLOTS];
   logic [16:0]   remain_ff, remain_in;
   logic [3:0]    count_ff, count_in;
   logic [7:0]    walk_ff, walk_in;
   rsp_type       rsp_ff, rsp_in;
   logic          more_ff, more_in;

   // slot write controls
   logic          wr_en, wr_ack, wr_stamp;
   logic [SW-1:0] wr_idx, ack_idx, stamp_idx;
   logic [RW-1:0] wr_off;
   logic [8:0]    wr_len;

   logic [7:0]    used;
   logic          win_full;
   logic [RW-1:0] sp_off, sp_cap;
   logic [RW-1:0] sp_thr;
   logic          sp_ok;
   logic [8:0]    maxp;
   logic [RW-1:0] cap_lim;
   logic [16:0]   room, cur;
   logic [SW-1:0] wi;
   logic [7:0]    nxt;
   logic [16:0]   rlen;

   assign used     = wtail_ff - whead_ff;
   assign win_full = (used >= 8'(WINDOW_SLOTS));
   assign maxp     = (csr.max_pkt_size == 8'd0) ? 9'd256 : {1'b0, csr.max_pkt_size};
   assign out_valid = (state_ff == ST_EMIT);
   assign out_close = (state_ff == ST_CLOSE);
   assign out_data  = rsp_ff;
   assign rlen      = {1'b0, cmd.payload_bytes} + 17'(HEADER_BYTES + CRC_BYTES);
   // reserve asks for its own length, stream packets for the overhead plus one byte
   assign sp_thr    = (state_ff == ST_IDLE) ? RW'(rlen[8:0]) : RW'(OVH + 1);

   // contiguous space at the tail, with wrap to zero
   always_comb begin
      if (used == 8'd0) begin
         sp_off = '0;
         sp_cap = RW'(RING_BYTES);
      end else if (rhead_ff >= rtail_ff) begin
         sp_off = rtail_ff;
         sp_cap = rhead_ff - rtail_ff;
      end else if ((RW'(RING_BYTES) - rtail_ff) < sp_thr) begin
         sp_off = '0;
         sp_cap = rhead_ff;
      end else begin
         sp_off = rtail_ff;
         sp_cap = RW'(RING_BYTES) - rtail_ff;
      end
      sp_ok = (sp_cap >= sp_thr);
   end

   always_comb begin
      state_in  = state_ff;
      whead_in  = whead_ff;
      wtail_in  = wtail_ff;
      age_in    = age_ff;
      rhead_in  = rhead_ff;
      rtail_in  = rtail_ff;
      valid_in  = valid_ff;
      remain_in = remain_ff;
      count_in  = count_ff;
      walk_in   = walk_ff;
      rsp_in    = rsp_ff;
      more_in   = more_ff;
      cmd_pop   = 1'b0;
      wr_en     = 1'b0;
      wr_ack    = 1'b0;
      wr_stamp  = 1'b0;
      wr_idx    = wtail_ff[SW-1:0];
      ack_idx   = cmd.ack_seqnum[SW-1:0];
      stamp_idx = walk_ff[SW-1:0];
      wr_off    = sp_off;
      wr_len    = '0;
      cap_lim   = '0;
      room      = '0;
      cur       = '0;
      wi        = walk_ff[SW-1:0];
      nxt       = walk_ff + 8'd1;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               rsp_in  = '0;
               rsp_in.last = 1'b1;
               more_in = 1'b0;
               case (kind_type'(cmd.kind))
                  KIND_RESERVE: begin
                     if (used == 8'd0) begin
                        rhead_in = '0;
                        rtail_in = '0;
                     end
                     if (!win_full && rlen <= 17'(MAX_LEN) && sp_ok) begin
                        wr_en  = 1'b1;
                        wr_len = rlen[8:0];
                        rtail_in = (sp_off + RW'(rlen[8:0]) >= RW'(RING_BYTES)) ? '0
                                   : sp_off + RW'(rlen[8:0]);
                        wtail_in = wtail_ff + 8'd1;
                        rsp_in.ok = 1'b1;
                        rsp_in.seqnum = wtail_ff;
                        rsp_in.buffer_offset = 10'(sp_off);
                        rsp_in.pkt_length = rlen[8:0];
                     end
                     state_in = ST_EMIT;
                  end
                  KIND_STREAM: begin
                     remain_in = {1'b0, cmd.payload_bytes};
                     count_in  = '0;
                     state_in  = ST_STREAM;
                  end
                  KIND_ACK: begin
                     if (valid_ff[cmd.ack_seqnum[SW-1:0]]) begin
                        wr_ack = 1'b1;
                        rsp_in.ok = 1'b1;
                        if (cmd.ack_seqnum == whead_ff) begin
                           walk_in  = cmd.ack_seqnum;
                           state_in = ST_ACK_WALK;
                        end else begin
                           state_in = ST_EMIT;
                        end
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                     walk_in = whead_ff;
                     state_in = (used == 8'd0) ? ST_EMIT : ST_POLL_WALK;
                  end
               endcase
            end
         end
         ST_STREAM: begin
            // one packet per visit; the next is taken only after this one is handed over
            if (used == 8'd0) begin
               rhead_in = '0;
               rtail_in = '0;
            end
            cap_lim = (sp_cap > RW'(maxp)) ? RW'(maxp) : sp_cap;
            room    = 17'(cap_lim) - 17'(OVH);
            if (remain_ff == '0 || count_ff == 4'(RESULT_CAP) || win_full || !sp_ok
                || cap_lim <= RW'(OVH)) begin
               if (count_ff == '0) begin
                  rsp_in = '0;
                  rsp_in.last = 1'b1;
                  more_in = 1'b0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_CLOSE;
               end
            end else begin
               cur = (remain_ff < room) ? remain_ff : room;
               wr_en  = 1'b1;
               wr_len = 9'(cur + 17'(OVH));
               rtail_in = (sp_off + RW'(wr_len) >= RW'(RING_BYTES)) ? '0
                          : sp_off + RW'(wr_len);
               wtail_in = wtail_ff + 8'd1;
               remain_in = remain_ff - cur;
               count_in  = count_ff + 4'd1;
               rsp_in.ok = 1'b1;
               rsp_in.seqnum = wtail_ff;
               rsp_in.buffer_offset = 10'(sp_off);
               rsp_in.pkt_length = wr_len;
               rsp_in.payload_taken = 9'(cur);
               // last is set by the result queue when the stream closes
               rsp_in.last = 1'b0;
               more_in = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_ACK_WALK: begin
            valid_in[wi] = 1'b0;
            whead_in = nxt;
            walk_in  = nxt;
            if (nxt == wtail_ff) begin
               rhead_in = '0;
               rtail_in = '0;
               state_in = ST_EMIT;
            end else begin
               rhead_in = off_ff[nxt[SW-1:0]];
               if (!acked_ff[nxt[SW-1:0]]) state_in = ST_EMIT;
            end
         end
         ST_POLL_WALK: begin
            if (valid_ff[wi] && !acked_ff[wi]
                && (age_ff - stamp_ff[wi]) >= csr.retransmit_age) begin
               wr_stamp = 1'b1;
               rsp_in.ok = 1'b1;
               rsp_in.seqnum = walk_ff;
               rsp_in.buffer_offset = 10'(off_ff[wi]);
               rsp_in.pkt_length = len_ff[wi];
               state_in = ST_EMIT;
            end else begin
               walk_in = nxt;
               if (nxt == wtail_ff) begin
                  age_in = age_ff + 8'd1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_ready) state_in = more_ff ? ST_STREAM : ST_IDLE;
         end
         ST_CLOSE: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         whead_ff <= '0;
         wtail_ff <= '0;
         age_ff   <= '0;
         rhead_ff <= '0;
         rtail_ff <= '0;
         valid_ff <= '0;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         whead_ff <= whead_in;
         wtail_ff <= wtail_in;
         age_ff   <= age_in;
         rhead_ff <= rhead_in;
         rtail_ff <= rtail_in;
         valid_ff <= wr_en ? (valid_in | (WINDOW_SLOTS'(1) << wr_idx)) : valid_in;
         more_ff  <= more_in;
      end
      remain_ff <= remain_in;
      count_ff  <= count_in;
      walk_ff   <= walk_in;
      rsp_ff    <= rsp_in;
      if (wr_en) begin
         acked_ff[wr_idx] <= 1'b0;
         off_ff[wr_idx]   <= wr_off;
         len_ff[wr_idx]   <= wr_len;
         stamp_ff[wr_idx] <= age_ff;
      end
      if (wr_ack) acked_ff[ack_idx] <= 1'b1;
      if (wr_stamp) stamp_ff[stamp_idx] <= age_ff;
   end
endmodule

>>> design/srsw_out.sv
// srsw_out: result queue with stream last-flag fixup
// depends on srsw_pkg
module srsw_out
   import srsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   input  logic    in_close,
   output logic    in_ready,
   output logic    empty,
   output rsp_type data,
   input  logic    pop
);
   // one held stream packet: sent once the next one or the close arrives
   rsp_type hold_ff, hold_in;
   rsp_type out_ff, out_in;
   logic    hold_v_ff, hold_v_in, out_v_ff, out_v_in;
   logic    out_free;

   assign empty    = !out_v_ff;
   assign data     = out_ff;
   assign out_free = !out_v_ff || pop;
   assign in_ready = out_free || (!hold_v_ff && !in_data.last);

   always_comb begin
      hold_in   = hold_ff;
      hold_v_in = hold_v_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !pop;
      if (in_close && hold_v_ff && out_free) begin
         out_in      = hold_ff;
         out_in.last = 1'b1;
         out_v_in    = 1'b1;
         hold_v_in   = 1'b0;
      end else if (in_valid && in_ready) begin
         if (in_data.last) begin
            out_in   = in_data;
            out_v_in = 1'b1;
         end else begin
            if (hold_v_ff) begin
               out_in   = hold_ff;
               out_v_in = 1'b1;
            end
            hold_in   = in_data;
            hold_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end
endmodule

>>> verif/testbench.sv
// testbench: random and directed checks of the selective repeat send window
// depends on srsw_pkg and selective_repeat_send_window; holds its own window predictor
`timescale 1ns / 100ps

module testbench;
   import srsw_pkg::*;

   localparam int SLOTS = 8;
   localparam int RING = 1024;
   localparam int HDR = 4;
   localparam int SHDR = 6;
   localparam int LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [7:0] csr_data = '0;

   selective_repeat_send_window i_dut (
      .clock, .reset, .req_push, .req_full, .req_data, .rsp_empty, .rsp_pop,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0] win_head, win_tail, age_clk;
   int unsigned ring_head, ring_tail;
   bit slot_valid [SLOTS];
   bit slot_acked [SLOTS];
   int unsigned slot_off [SLOTS];
   int unsigned slot_len [SLOTS];
   logic [7:0] slot_stamp [SLOTS];
   int unsigned max_pkt, retx_age;

   rsp_type expected_rsp[$];
   req_type pending_req[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   function automatic rsp_type make_rsp(bit ok, logic [7:0] seq, int unsigned off,
                                        int unsigned len, int unsigned taken, bit last);
      rsp_type r;
      r.ok = ok; r.seqnum = seq; r.buffer_offset = off[9:0];
      r.pkt_length = len[8:0]; r.payload_taken = taken[8:0]; r.last = last;
      return r;
   endfunction

   function automatic int unsigned find_space(int unsigned thr, output int unsigned off);
      int unsigned cap;
      if (win_tail == win_head) begin
         ring_head = 0; ring_tail = 0; off = 0; cap = RING;
      end else begin
         off = ring_tail;
         if (ring_head >= ring_tail) cap = ring_head - ring_tail;
         else begin
            cap = RING - ring_tail;
            if (cap < thr) begin
               off = 0; cap = ring_head;
            end
         end
      end
      return cap >= thr ? cap : 0;
   endfunction

   function automatic logic [7:0] take_slot(int unsigned off, int unsigned len);
      logic [7:0] seq = win_tail;
      int i = seq % SLOTS;
      slot_valid[i] = 1; slot_acked[i] = 0; slot_off[i] = off;
      slot_len[i] = len; slot_stamp[i] = age_clk;
      ring_tail = off + len;
      if (ring_tail >= RING) ring_tail = 0;
      win_tail = win_tail + 8'd1;
      return seq;
   endfunction

   function automatic void predict_window(req_type rq);
      int unsigned off, cap, cur, len, rem, maxp;
      logic [7:0] s;
      int i, n;
      bit done;
      logic [7:0] used;
      used = win_tail - win_head;
      case (kind_type'(rq.kind))
         KIND_RESERVE: begin
            len = 32'(rq.payload_bytes) + HDR + CRC_BYTES;
            if (used >= SLOTS || len > MAX_LEN || find_space(len, off) == 0)
               expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            else begin
               s = take_slot(off, len);
               expected_rsp.push_back(make_rsp(1, s, off, len, 0, 1));
            end
         end
         KIND_STREAM: begin
            maxp = max_pkt == 0 ? MAX_LEN : max_pkt;
            rem = 32'(rq.payload_bytes);
            n = 0;
            done = 0;
            while (rem > 0 && n < RESULT_CAP && !done) begin
               if (8'(win_tail - win_head) >= SLOTS) done = 1;
               else begin
                  cap = find_space(SHDR + CRC_BYTES + 1, off);
                  if (cap > maxp) cap = maxp;
                  if (cap <= SHDR + CRC_BYTES) done = 1;
                  else begin
                     cur = rem < cap - SHDR - CRC_BYTES ? rem : cap - SHDR - CRC_BYTES;
                     s = take_slot(off, cur + SHDR + CRC_BYTES);
                     expected_rsp.push_back(make_rsp(1, s, off, cur + SHDR + CRC_BYTES,
                                                     cur, 0));
                     n++;
                     rem -= cur;
                  end
               end
            end
            if (n == 0) expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            else expected_rsp[$].last = 1;
         end
         KIND_ACK: begin
            s = rq.ack_seqnum;
            i = s % SLOTS;
            if (!slot_valid[i]) expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            else begin
               slot_acked[i] = 1;
               if (s == win_head) begin
                  for (int k = 0; k < SLOTS; k++) begin
                     slot_valid[s % SLOTS] = 0;
                     s = s + 8'd1;
                     win_head = s;
                     if (s == win_tail) begin
                        ring_head = 0; ring_tail = 0; break;
                     end
                     ring_head = slot_off[s % SLOTS];
                     if (!slot_acked[s % SLOTS]) break;
                  end
               end
               expected_rsp.push_back(make_rsp(1, 0, 0, 0, 0, 1));
            end
         end
         default: begin
            s = win_head;
            done = 0;
            if (s == win_tail) begin
               expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
               done = 1;
            end
            for (int k = 0; k < SLOTS && s != win_tail && !done; k++) begin
               i = s % SLOTS;
               if (slot_valid[i] && !slot_acked[i] &&
                   int'(8'(age_clk - slot_stamp[i])) >= retx_age) begin
                  slot_stamp[i] = age_clk;
                  expected_rsp.push_back(make_rsp(1, s, slot_off[i], slot_len[i], 0, 1));
                  done = 1;
               end
               s = s + 8'd1;
            end
            if (!done) begin
               age_clk = age_clk + 8'd1;
               expected_rsp.push_back(make_rsp(0, 0, 0, 0, 0, 1));
            end
         end
      endcase
   endfunction

   // accept decision sampled at the rising edge
   logic req_full_q;
   always @(posedge clock) req_full_q <= req_full;

   // request driver with random idle bursts
   int send_gap = 0;
   bit hold_sender = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_full_q) begin
            predict_window(req_data);
            void'(pending_req.pop_front());
         end
         if (send_gap > 0) send_gap--;
         else if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 17);
         if (pending_req.size() > 0 && send_gap == 0 && !hold_sender) begin
            req_push <= 1'b1;
            req_data <= pending_req[0];
         end else
            req_push <= 1'b0;
      end
   end

   // result monitor with random stall bursts
   int pop_gap = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsp.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_data.ok !== e.ok) begin
               $error("ok exp %0d got %0d", e.ok, rsp_data.ok); errors++;
            end
            if (rsp_data.seqnum !== e.seqnum) begin
               $error("seqnum exp %0d got %0d", e.seqnum, rsp_data.seqnum); errors++;
            end
            if (rsp_data.buffer_offset !== e.buffer_offset) begin
               $error("buffer_offset exp %0d got %0d", e.buffer_offset,
                      rsp_data.buffer_offset); errors++;
            end
            if (rsp_data.pkt_length !== e.pkt_length) begin
               $error("pkt_length exp %0d got %0d", e.pkt_length,
                      rsp_data.pkt_length); errors++;
            end
            if (rsp_data.payload_taken !== e.payload_taken) begin
               $error("payload_taken exp %0d got %0d", e.payload_taken,
                      rsp_data.payload_taken); errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         pop_gap = $urandom_range(1, 17);
         rsp_pop <= 1'b0;
      end else
         rsp_pop <= 1'b1;
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_req.size() > 0 || req_push) @(negedge clock);
      while (expected_rsp.size() > 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MAX_PACKET) max_pkt = 32'(value);
      else retx_age = 32'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk(kind_type k, logic [15:0] b, logic [7:0] a);
      req_type r;
      r.kind = k; r.payload_bytes = b; r.ack_seqnum = a;
      return r;
   endfunction

   // mostly legal traffic: small reserves/streams, acks near the window head
   function automatic req_type random_req();
      int p = $urandom_range(0, 99);
      logic [7:0] a;
      if (p < 30)
         return mk(KIND_RESERVE, (p < 3) ? 16'($urandom) : 16'($urandom_range(0, 250)),
                   8'($urandom));
      if (p < 50)
         return mk(KIND_STREAM, (p < 33) ? 16'($urandom) : 16'($urandom_range(0, 900)),
                   8'($urandom));
      if (p < 80) begin
         a = win_head + 8'($urandom_range(0, 7));
         if ($urandom_range(0, 7) == 0) a = 8'($urandom);
         return mk(KIND_ACK, 16'($urandom), a);
      end
      return mk(KIND_POLL, 16'($urandom), 8'($urandom));
   endfunction

   initial begin
      win_head = 0; win_tail = 0; age_clk = 0; ring_head = 0; ring_tail = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 0; slot_acked[i] = 0; slot_off[i] = 0; slot_len[i] = 0;
         slot_stamp[i] = 0;
      end
      max_pkt = 0; retx_age = 4;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every kind, refusals, aliasing
      pending_req.push_back(mk(KIND_POLL, 16'd0, 8'd0));
      pending_req.push_back(mk(KIND_ACK, 16'hffff, 8'hff));
      pending_req.push_back(mk(KIND_STREAM, 16'd0, 8'd0));
      pending_req.push_back(mk(KIND_RESERVE, 16'd248, 8'd0));
      pending_req.push_back(mk(KIND_RESERVE, 16'd249, 8'd0));
      pending_req.push_back(mk(KIND_RESERVE, 16'hffff, 8'd0));
      pending_req.push_back(mk(KIND_RESERVE, 16'd0, 8'd0));
      pending_req.push_back(mk(KIND_STREAM, 16'hffff, 8'd0));
      pending_req.push_back(mk(KIND_RESERVE, 16'd10, 8'd0));
      pending_req.push_back(mk(KIND_ACK, 16'd0, 8'd9));
      pending_req.push_back(mk(KIND_ACK, 16'd0, 8'd0));
      for (int k = 0; k < 6; k++) pending_req.push_back(mk(KIND_POLL, 16'd0, 8'd0));
      pending_req.push_back(mk(KIND_ACK, 16'd0, 8'd2));
      pending_req.push_back(mk(KIND_ACK, 16'd0, 8'd1));
      wait_drained();

      write_csr(CSR_MAX_PACKET, 8'd10);
      write_csr(CSR_RETX_AGE, 8'd1);
      pending_req.push_back(mk(KIND_STREAM, 16'd100, 8'd0));
      pending_req.push_back(mk(KIND_POLL, 16'd0, 8'd0));
      wait_drained();
      write_csr(CSR_MAX_PACKET, 8'd11);
      pending_req.push_back(mk(KIND_STREAM, 16'd5, 8'd0));
      wait_drained();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(CSR_MAX_PACKET, 8'd0);   write_csr(CSR_RETX_AGE, 8'd255); end
            1: begin write_csr(CSR_MAX_PACKET, 8'd255); write_csr(CSR_RETX_AGE, 8'd2);   end
            2: begin write_csr(CSR_MAX_PACKET, 8'd40);  write_csr(CSR_RETX_AGE, 8'd1);   end
            3: begin write_csr(CSR_MAX_PACKET, 8'd0);   write_csr(CSR_RETX_AGE, 8'd0);   end
            4: begin write_csr(CSR_MAX_PACKET, 8'($urandom_range(11, 255)));
                      write_csr(CSR_RETX_AGE, 8'($urandom_range(1, 8))); end
            default: begin write_csr(CSR_MAX_PACKET, 8'd64); write_csr(CSR_RETX_AGE, 8'd3);
                           quiet = 1'b1; end
         endcase
         for (int n = 0; n < 48; n++) begin
            // predictor advances as items go out, so build items lazily
            while (pending_req.size() > 1) @(negedge clock);
            pending_req.push_back(random_req());
            if (ph == 2 && n == 20) begin
               hold_sender = 1'b1;
               while (pending_req.size() > 0 || req_push) begin
                  hold_sender = 1'b0;
                  @(negedge clock);
               end
               hold_sender = 1'b1;
               while (expected_rsp.size() > 0) @(negedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_drained();
      end

      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> selective_repeat_send_window.f
design/srsw_pkg.sv
design/srsw_fifo.sv
design/srsw_engine.sv
design/srsw_out.sv
design/selective_repeat_send_window.sv
verif/testbench.sv
